>>> rtl/sorted_key_priority_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// Sorted key priority queue assertion macros
// Concurrent assertion helpers used by the queue controller. Defining ASSERT_OFF
// turns every macro into an empty body.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_KEY_PRIORITY_QUEUE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// The condition holds at every clock edge outside reset.
`define SKPQ_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("skpq assertion failed");

// When the antecedent holds, the consequent holds at the following clock edge.
`define SKPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("skpq assertion failed");

`else

`define SKPQ_ASSERT_ALWAYS(label, clk, rst, cond)
`define SKPQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/skpq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key priority queue package
// Sizes, request and status codes, and the structs passed between the
// queue controller and the storage cells.
// ----------------------------------------------------------------------------
`default_nettype none

package skpq_pkg;

  // Number of entries the queue holds.
  localparam int CAPACITY = 16;
  // Width of a slot index and of the entry count.
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Key and payload widths.
  localparam int KEY_W = 32;
  localparam int PAY_W = 32;

  // Request kinds.
  typedef enum logic [1:0] {
    KIND_INSERT   = 2'd0,
    KIND_PREPEND  = 2'd1,
    KIND_POSTPEND = 2'd2,
    KIND_REMOVE   = 2'd3
  } skpq_kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_DUP   = 2'd3
  } skpq_status_t;

  // Per-cell update command: load the new entry, take the neighbor toward
  // the head, or take the neighbor toward the tail.
  typedef struct packed {
    logic load;
    logic take_prev;
    logic take_next;
  } skpq_cell_op_t;

  // Per-cell compare of the request key against the stored key.
  typedef struct packed {
    logic key_lt;
    logic key_eq;
  } skpq_cell_cmp_t;

endpackage

`default_nettype wire

>>> rtl/sorted_key_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// Sorted key priority queue unit
// Bounded queue of key and payload entries held in ascending key order in a
// row of shifting cells; a prepend or postpend key that wraps breaks the order.
// ----------------------------------------------------------------------------
// A request (insert, prepend, postpend or remove head) is taken on any cycle
// that start is high; busy is never raised, so one request per clock cycle is
// sustained. The result appears on status, out_key, out_payload and occupancy
// with done high for exactly one cycle, in the cycle after the request is taken;
// the receiver cannot stall it and must capture it then. All the work of a
// request happens in the cycle it is taken: every cell compares the request
// key with its own key in parallel, the controller picks the slot, and the
// row of cells shifts and loads at that clock edge. Results come out in
// request order, one for each request.
`default_nettype none

module sorted_key_priority_queue_unit
  import skpq_pkg::*;
(
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  wire logic        [1:0]       kind,
  input  wire logic signed [KEY_W-1:0] key,
  input  wire logic        [PAY_W-1:0] payload,
  output logic                         done,
  output logic        [1:0]            status,
  output logic signed [KEY_W-1:0]      out_key,
  output logic        [PAY_W-1:0]      out_payload,
  output logic        [CNT_W-1:0]      occupancy
);

  logic signed [KEY_W-1:0] cell_key     [CAPACITY];
  logic        [PAY_W-1:0] cell_payload [CAPACITY];
  skpq_cell_cmp_t          cell_cmp     [CAPACITY];
  skpq_cell_op_t           cell_op      [CAPACITY];
  logic signed [KEY_W-1:0] prev_key     [CAPACITY];
  logic        [PAY_W-1:0] prev_payload [CAPACITY];
  logic signed [KEY_W-1:0] next_key     [CAPACITY];
  logic        [PAY_W-1:0] next_payload [CAPACITY];
  logic signed [KEY_W-1:0] new_key;
  logic        [PAY_W-1:0] new_payload;

  // Controller.
  skpq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .kind         (kind),
    .key          (key),
    .payload      (payload),
    .cell_key     (cell_key),
    .cell_payload (cell_payload),
    .cell_cmp     (cell_cmp),
    .cell_op      (cell_op),
    .new_key      (new_key),
    .new_payload  (new_payload),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .out_key      (out_key),
    .out_payload  (out_payload),
    .occupancy    (occupancy)
  );

  // Row of cells, each linked to its neighbors toward head and tail.
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign prev_key[j]     = new_key;
      assign prev_payload[j] = new_payload;
    end else begin : g_body
      assign prev_key[j]     = cell_key[j-1];
      assign prev_payload[j] = cell_payload[j-1];
    end
    if (j == CAPACITY - 1) begin : g_tail
      assign next_key[j]     = cell_key[j];
      assign next_payload[j] = cell_payload[j];
    end else begin : g_link
      assign next_key[j]     = cell_key[j+1];
      assign next_payload[j] = cell_payload[j+1];
    end

    skpq_cell u_cell (
      .clk          (clk),
      .op           (cell_op[j]),
      .req_key      (key),
      .new_key      (new_key),
      .new_payload  (new_payload),
      .prev_key     (prev_key[j]),
      .prev_payload (prev_payload[j]),
      .next_key     (next_key[j]),
      .next_payload (next_payload[j]),
      .key          (cell_key[j]),
      .payload      (cell_payload[j]),
      .cmp          (cell_cmp[j])
    );
  end

endmodule

`default_nettype wire

>>> rtl/skpq_cell.sv
// ----------------------------------------------------------------------------
// Sorted key priority queue cell
// One queue slot: holds a key and payload, compares the request key against
// its own key, and loads a new entry or a neighbor's entry on command.
// ----------------------------------------------------------------------------
`default_nettype none

module skpq_cell
  import skpq_pkg::*;
(
  input  wire                     clk,
  input  wire skpq_cell_op_t      op,
  input  wire logic signed [KEY_W-1:0] req_key,
  input  wire logic signed [KEY_W-1:0] new_key,
  input  wire logic        [PAY_W-1:0] new_payload,
  input  wire logic signed [KEY_W-1:0] prev_key,
  input  wire logic        [PAY_W-1:0] prev_payload,
  input  wire logic signed [KEY_W-1:0] next_key,
  input  wire logic        [PAY_W-1:0] next_payload,
  output logic signed [KEY_W-1:0] key,
  output logic        [PAY_W-1:0] payload,
  output skpq_cell_cmp_t          cmp
);

  // Slot storage; contents are meaningful only below the entry count.
  always_ff @(posedge clk) begin
    if (op.load) begin
      key     <= new_key;
      payload <= new_payload;
    end else if (op.take_prev) begin
      key     <= prev_key;
      payload <= prev_payload;
    end else if (op.take_next) begin
      key     <= next_key;
      payload <= next_payload;
    end
  end

  // Signed compare of the request key against the stored key.
  always_comb begin
    cmp.key_lt = (req_key < key);
    cmp.key_eq = (req_key == key);
  end

endmodule

`default_nettype wire

>>> rtl/skpq_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted key priority queue controller
// Decodes each request, picks the insert slot from the cell compares, drives
// the per-cell shift and load commands, and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_key_priority_queue_unit_assert.svh"

module skpq_ctrl
  import skpq_pkg::*;
(
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire logic        [1:0]       kind,
  input  wire logic signed [KEY_W-1:0] key,
  input  wire logic        [PAY_W-1:0] payload,
  input  wire logic signed [KEY_W-1:0] cell_key [CAPACITY],
  input  wire logic        [PAY_W-1:0] cell_payload [CAPACITY],
  input  wire skpq_cell_cmp_t          cell_cmp [CAPACITY],
  output skpq_cell_op_t                cell_op  [CAPACITY],
  output logic signed [KEY_W-1:0]      new_key,
  output logic        [PAY_W-1:0]      new_payload,
  output logic                         busy,
  output logic                         done,
  output logic        [1:0]            status,
  output logic signed [KEY_W-1:0]      out_key,
  output logic        [PAY_W-1:0]      out_payload,
  output logic        [CNT_W-1:0]      occupancy
);

  logic               accept;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               full;
  logic               do_ins;
  logic               do_rem;
  logic [IDX_W-1:0]   ins_pos;
  logic [IDX_W-1:0]   tail_idx;
  skpq_status_t       st;
  skpq_kind_t         req_kind;

  // Every request is taken as soon as start is high, so the unit never stalls.
  assign busy     = 1'b0;
  assign accept   = start;
  assign req_kind = skpq_kind_t'(kind);
  assign full     = (count == CNT_W'(CAPACITY));
  assign tail_idx = IDX_W'(count - CNT_W'(1));

  // Request decode and insert slot search.
  always_comb begin
    do_ins      = 1'b0;
    do_rem      = 1'b0;
    ins_pos     = count[IDX_W-1:0];
    st          = ST_DONE;
    new_key     = key;
    new_payload = payload;
    if (req_kind == KIND_REMOVE) begin
      if (count == '0) begin
        st = ST_EMPTY;
      end else begin
        do_rem = 1'b1;
      end
    end else if (full) begin
      st = ST_FULL;
    end else begin
      case (req_kind)
        KIND_PREPEND: begin
          new_key = (count == '0) ? '0 : cell_key[0] - KEY_W'(1);
          ins_pos = '0;
          do_ins  = 1'b1;
        end
        KIND_POSTPEND: begin
          new_key = (count == '0) ? '0 : cell_key[tail_idx] + KEY_W'(1);
          do_ins  = 1'b1;
        end
        default: begin
          if (count == '0 || cell_cmp[0].key_lt) begin
            ins_pos = '0;
            do_ins  = 1'b1;
          end else if (cell_cmp[0].key_eq) begin
            st = ST_DUP;
          end else begin
            // First occupied slot past the head whose key is not below the
            // request key; the tail end when there is none.
            for (int j = CAPACITY - 1; j >= 1; j--) begin
              if (CNT_W'(j) < count && (cell_cmp[j].key_lt || cell_cmp[j].key_eq)) begin
                ins_pos = IDX_W'(j);
              end
            end
            if ({1'b0, ins_pos} < count && cell_cmp[ins_pos].key_eq) begin
              st = ST_DUP;
            end else begin
              do_ins = 1'b1;
            end
          end
        end
      endcase
    end
  end

  // Cell commands: open a gap at the insert slot, or pull everything one
  // slot toward the head on a removal.
  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      cell_op[j].load      = accept && do_ins && (IDX_W'(j) == ins_pos);
      cell_op[j].take_prev = accept && do_ins && (IDX_W'(j) > ins_pos);
      cell_op[j].take_next = accept && do_rem && (j < CAPACITY - 1);
    end
  end

  // Entry count update.
  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + CNT_W'(1);
    end else if (do_rem) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Count and registered result. The removed entry comes from the head cell
  // before it shifts.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
    if (accept) begin
      status      <= st;
      out_key     <= do_rem ? cell_key[0] : '0;
      out_payload <= do_rem ? cell_payload[0] : '0;
      occupancy   <= count_next;
    end
  end

  `SKPQ_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(CAPACITY))
  `SKPQ_ASSERT_NEXT(a_result_strobe, clk, rst, accept, done && occupancy == count)
  `SKPQ_ASSERT_NEXT(a_remove_shrinks, clk, rst,
    accept && req_kind == KIND_REMOVE && count != '0,
    count == CNT_W'($past(count) - CNT_W'(1)))
  `SKPQ_ASSERT_NEXT(a_full_drops, clk, rst,
    accept && req_kind != KIND_REMOVE && full,
    status == ST_FULL && count == CNT_W'(CAPACITY))

endmodule

`default_nettype wire

>>> tb/sv/sorted_key_priority_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// Sorted key priority queue unit testbench
// Drives insert, prepend, postpend and remove-head requests in random bursts.
// A shadow copy of the queue predicts every result. A short directed table
// covers the empty queue, key wrap, duplicates and the full queue. A random
// phase then swings between filling and draining.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_priority_queue_unit_tb
  import skpq_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
  localparam int RANDOM_REQUESTS = 450;

  typedef struct {
    skpq_status_t      status;
    logic [KEY_W-1:0]  okey;
    logic [PAY_W-1:0]  opay;
    logic [CNT_W-1:0]  occ;
  } result_t;

  typedef struct {
    skpq_kind_t               kind;
    logic signed [KEY_W-1:0]  key;
    logic [PAY_W-1:0]         pay;
    bit                       typed;
    result_t                  exp;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  skpq_kind_t               kind = KIND_INSERT;
  logic signed [KEY_W-1:0]  key = '0;
  logic [PAY_W-1:0]         payload = '0;
  logic                     done;
  logic [1:0]               status;
  logic signed [KEY_W-1:0]  out_key;
  logic [PAY_W-1:0]         out_payload;
  logic [CNT_W-1:0]         occupancy;

  // Typed expectation that travels with the current directed request.
  bit                       typed_on = 1'b0;
  result_t                  typed_exp;

  // Shadow copy of the queue contents, slot 0 is the head.
  logic signed [KEY_W-1:0]  shadow_key [CAPACITY];
  logic [PAY_W-1:0]         shadow_pay [CAPACITY];
  int                       shadow_count;

  result_t                  pending_results[$];
  stim_row_t                directed_rows[$];
  logic signed [KEY_W-1:0]  recent_keys [8];
  int                       recent_ptr;
  int                       burst_left;
  int                       mismatches;
  int                       requests_sent;
  int                       results_checked;
  int                       full_drops;
  int                       dup_drops;
  int                       empty_removes;
  int                       peak_occ;

  sorted_key_priority_queue_unit dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .key         (key),
    .payload     (payload),
    .done        (done),
    .status      (status),
    .out_key     (out_key),
    .out_payload (out_payload),
    .occupancy   (occupancy)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic result_t make_result(skpq_status_t st, logic [KEY_W-1:0] ok,
                                          logic [PAY_W-1:0] op, logic [CNT_W-1:0] oc);
    result_t r;
    r.status = st;
    r.okey   = ok;
    r.opay   = op;
    r.occ    = oc;
    return r;
  endfunction

  // Shift the tail down by one slot and write the new entry at pos.
  function automatic void place_entry(int pos, logic signed [KEY_W-1:0] k,
                                      logic [PAY_W-1:0] p);
    for (int i = shadow_count; i > pos; i--) begin
      shadow_key[i] = shadow_key[i-1];
      shadow_pay[i] = shadow_pay[i-1];
    end
    shadow_key[pos] = k;
    shadow_pay[pos] = p;
    shadow_count++;
  endfunction

  // Apply one request to the shadow queue and return the result it gives.
  function automatic result_t queue_apply(skpq_kind_t k, logic signed [KEY_W-1:0] rk,
                                          logic [PAY_W-1:0] rp);
    result_t                  r;
    logic signed [KEY_W-1:0]  nk;
    int                       i;
    r = make_result(ST_DONE, '0, '0, '0);
    if (k == KIND_REMOVE) begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.okey = shadow_key[0];
        r.opay = shadow_pay[0];
        for (int j = 1; j < shadow_count; j++) begin
          shadow_key[j-1] = shadow_key[j];
          shadow_pay[j-1] = shadow_pay[j];
        end
        shadow_count--;
      end
    end else if (shadow_count >= CAPACITY) begin
      r.status = ST_FULL;
    end else if (k == KIND_PREPEND) begin
      // Head minus one wraps without any check.
      nk = (shadow_count == 0) ? '0 : shadow_key[0] - 1;
      place_entry(0, nk, rp);
    end else if (k == KIND_POSTPEND) begin
      nk = (shadow_count == 0) ? '0 : shadow_key[shadow_count-1] + 1;
      place_entry(shadow_count, nk, rp);
    end else begin
      // Insert: before the head if below it, else after the first entry whose
      // successor is not below the key; an equal neighbor drops the request.
      if (shadow_count == 0 || rk < shadow_key[0]) begin
        place_entry(0, rk, rp);
      end else if (rk == shadow_key[0]) begin
        r.status = ST_DUP;
      end else begin
        i = 0;
        while (i + 1 < shadow_count && shadow_key[i+1] < rk) i++;
        if (i + 1 == shadow_count) begin
          place_entry(shadow_count, rk, rp);
        end else if (shadow_key[i+1] == rk) begin
          r.status = ST_DUP;
        end else begin
          place_entry(i + 1, rk, rp);
        end
      end
    end
    r.occ = shadow_count[CNT_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Check each result against the oldest expectation, then predict the
  // request taken at this edge.
  always @(posedge clk) begin
    result_t want;
    result_t pred;
    if (rst) begin
      shadow_count = 0;
      pending_results.delete();
    end else begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: result with no request waiting, status %h", $time, status);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("out_key", want.okey, out_key);
          check_field("out_payload", want.opay, out_payload);
          check_field("occupancy", 32'(want.occ), 32'(occupancy));
          results_checked++;
        end
      end
      if (start && !busy) begin
        pred = queue_apply(kind, key, payload);
        if (pred.status == ST_FULL) full_drops++;
        if (pred.status == ST_DUP) dup_drops++;
        if (pred.status == ST_EMPTY) empty_removes++;
        if (shadow_count > peak_occ) peak_occ = shadow_count;
        pending_results.push_back(typed_on ? typed_exp : pred);
      end
    end
  end

  // End a burst with a random gap, then pick the length of the next burst.
  task automatic pace();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
    end
  endtask

  task automatic send_request(skpq_kind_t k, logic signed [KEY_W-1:0] kv,
                              logic [PAY_W-1:0] pv, bit typed, result_t exp);
    start     <= 1'b1;
    kind      <= k;
    key       <= kv;
    payload   <= pv;
    typed_on  <= typed;
    typed_exp <= exp;
    do @(posedge clk); while (busy);
    requests_sent++;
    pace();
  endtask

  function automatic stim_row_t make_row(skpq_kind_t k, logic signed [KEY_W-1:0] kv,
                                         logic [PAY_W-1:0] pv, bit typed, result_t exp);
    stim_row_t row;
    row.kind  = k;
    row.key   = kv;
    row.pay   = pv;
    row.typed = typed;
    row.exp   = exp;
    return row;
  endfunction

  // Insert keys: wide random, a narrow band around zero, recent keys for
  // duplicates, and the ends of the signed range.
  function automatic logic signed [KEY_W-1:0] pick_key();
    logic signed [KEY_W-1:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2: k = $urandom;
      3, 4, 5: k = int'($urandom_range(0, 64)) - 32;
      6, 7:    k = recent_keys[$urandom_range(0, 7)];
      8: begin
        case ($urandom_range(0, 3))
          0:       k = KEY_MIN;
          1:       k = KEY_MAX;
          2:       k = -1;
          default: k = '0;
        endcase
      end
      default: k = $urandom_range(0, 1) ? KEY_MIN + $urandom_range(0, 3)
                                        : KEY_MAX - $urandom_range(0, 3);
    endcase
    return k;
  endfunction

  initial begin
    result_t                  no_exp;
    skpq_kind_t               k;
    logic signed [KEY_W-1:0]  kv;
    logic [PAY_W-1:0]         pv;
    int                       r;
    int                       mode_left;
    bit                       filling;
    int                       directed_count;

    no_exp = make_result(ST_DONE, '0, '0, '0);
    for (int i = 0; i < 8; i++) recent_keys[i] = '0;
    burst_left = $urandom_range(1, 10);

    // Empty queue, key zero on prepend and postpend, duplicate of the head,
    // wrap of head minus one, interior duplicate, then fill and overflow.
    directed_rows.push_back(make_row(KIND_REMOVE, '0, '0, 1'b1,
                                     make_result(ST_EMPTY, '0, '0, CNT_W'(0))));
    directed_rows.push_back(make_row(KIND_PREPEND, KEY_MAX, 32'hffff_ffff, 1'b1,
                                     make_result(ST_DONE, '0, '0, CNT_W'(1))));
    directed_rows.push_back(make_row(KIND_REMOVE, KEY_MIN, '0, 1'b1,
                                     make_result(ST_DONE, '0, 32'hffff_ffff, CNT_W'(0))));
    directed_rows.push_back(make_row(KIND_POSTPEND, -1, '0, 1'b1,
                                     make_result(ST_DONE, '0, '0, CNT_W'(1))));
    directed_rows.push_back(make_row(KIND_INSERT, '0, 32'h0000_1234, 1'b1,
                                     make_result(ST_DUP, '0, '0, CNT_W'(1))));
    directed_rows.push_back(make_row(KIND_INSERT, KEY_MIN, 32'ha5a5_a5a5, 1'b1,
                                     make_result(ST_DONE, '0, '0, CNT_W'(2))));
    directed_rows.push_back(make_row(KIND_PREPEND, '0, 32'h5a5a_5a5a, 1'b0, no_exp));
    directed_rows.push_back(make_row(KIND_INSERT, KEY_MAX, 32'h0f0f_0f0f, 1'b0, no_exp));
    directed_rows.push_back(make_row(KIND_INSERT, -1, '0, 1'b0, no_exp));
    directed_rows.push_back(make_row(KIND_INSERT, 7, 32'h8000_0001, 1'b0, no_exp));
    directed_rows.push_back(make_row(KIND_INSERT, 7, 32'h7fff_fffe, 1'b0, no_exp));
    for (int i = 0; i < 11; i++) begin
      directed_rows.push_back(make_row(KIND_POSTPEND, $urandom, $urandom, 1'b0, no_exp));
    end
    directed_rows.push_back(make_row(KIND_INSERT, -1, 32'h1111_1111, 1'b1,
                                     make_result(ST_FULL, '0, '0, CNT_W'(CAPACITY))));
    directed_rows.push_back(make_row(KIND_PREPEND, '0, 32'h2222_2222, 1'b1,
                                     make_result(ST_FULL, '0, '0, CNT_W'(CAPACITY))));
    directed_rows.push_back(make_row(KIND_POSTPEND, '0, 32'h3333_3333, 1'b1,
                                     make_result(ST_FULL, '0, '0, CNT_W'(CAPACITY))));
    directed_count = directed_rows.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].kind, directed_rows[i].key, directed_rows[i].pay,
                   directed_rows[i].typed, directed_rows[i].exp);
    end

    // Random part: alternate between filling and draining stretches so the
    // queue keeps reaching both full and empty.
    filling   = 1'b0;
    mode_left = $urandom_range(10, 30);
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (mode_left == 0) begin
        filling   = !filling;
        mode_left = $urandom_range(20, 60);
      end
      mode_left--;
      r = $urandom_range(0, 99);
      if (filling) begin
        k = (r < 45) ? KIND_INSERT : (r < 57) ? KIND_PREPEND :
            (r < 70) ? KIND_POSTPEND : KIND_REMOVE;
      end else begin
        k = (r < 70) ? KIND_REMOVE : (r < 80) ? KIND_INSERT :
            (r < 90) ? KIND_PREPEND : KIND_POSTPEND;
      end
      kv = (k == KIND_INSERT) ? pick_key() : $urandom;
      case ($urandom_range(0, 15))
        0:       pv = '0;
        1:       pv = '1;
        default: pv = $urandom;
      endcase
      if (k == KIND_INSERT) begin
        recent_keys[recent_ptr] = kv;
        recent_ptr = (recent_ptr + 1) % 8;
      end
      send_request(k, kv, pv, 1'b0, no_exp);
    end

    // Drain: wait for every outstanding result, then keep watching the outputs
    // for stray strobes.
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Ran %0d requests (%0d directed), %0d results checked, peak occupancy %0d.",
             requests_sent, directed_count, results_checked, peak_occ);
    $display("Saw %0d full drops, %0d duplicate drops, %0d removes from an empty queue.",
             full_drops, dup_drops, empty_removes);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog for a hung handshake or missing results.
  initial begin
    #2_000_000;
    $display("Timeout with %0d results still outstanding.", pending_results.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
